// ===== rtl/multiport_pin_debouncer_defines.svh =====
// Assertion helpers shared by the verification files of the pin debouncer.
// Each macro expands to one labelled concurrent assertion, clocked on the
// rising edge and switched off while reset is held.
`ifndef MULTIPORT_PIN_DEBOUNCER_DEFINES_SVH
`define MULTIPORT_PIN_DEBOUNCER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pin debouncer check failed");

// Consequent must hold in the cycle after the antecedent.
`define MPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pin debouncer check failed");

`endif

// ===== rtl/mpd_pkg.sv =====
`timescale 1ns / 1ps

package mpd_pkg;

  // Build-time configuration.
  localparam int PORTS            = 4;
  localparam int PIN_WIDTH        = 32;
  localparam int SAMPLE_PERIOD_MS = 5;

  localparam int DEFAULT_SETTLE_MS = 20;
  localparam int PORT_IDX_W        = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam logic [3:0] PORT_LIMIT = 4'(PORTS);

  // Settle counters saturate rather than wrap.
  localparam int COUNT_W = 14;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Ceiling division of the settle time by the sample period, done as a
  // multiply by a rounded-up reciprocal. Exact for every numerator below
  // 2**DIV_NUM_W since the reciprocal error times the numerator stays under
  // 2**DIV_SHIFT.
  localparam int DIV_NUM_W    = 17;
  localparam int DIV_SHIFT    = DIV_NUM_W + $clog2(SAMPLE_PERIOD_MS);
  localparam longint DIV_RECIP =
    ((longint'(1) << DIV_SHIFT) + SAMPLE_PERIOD_MS - 1) / SAMPLE_PERIOD_MS;
  localparam int DIV_RECIP_W  = DIV_SHIFT + 1;
  localparam int DIV_PROD_W   = DIV_NUM_W + DIV_RECIP_W;

  // Item kinds.
  localparam logic FUNC_CONFIGURE = 1'b0;
  localparam logic FUNC_SAMPLE    = 1'b1;

  typedef struct packed {
    logic        func;
    logic [2:0]  port;
    logic [31:0] levels;
    logic [31:0] pin_mask;
    logic [15:0] settle_ms;
    logic [15:0] elapsed;
  } mpd_in_t;

  typedef struct packed {
    logic [2:0]  event_port;
    logic [31:0] stable_out;
    logic [31:0] changed_bits;
    logic [31:0] event_number;
  } mpd_out_t;

endpackage

// ===== rtl/mpd_channels.sv =====
`timescale 1ns / 1ps

interface mpd_in_if import mpd_pkg::*; ();
  logic    valid;
  logic    ready;
  mpd_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mpd_out_if import mpd_pkg::*; ();
  logic     valid;
  logic     ready;
  mpd_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/multiport_pin_debouncer.sv =====
`timescale 1ns / 1ps

// Multiport pin debouncer.
// Words arrive on in_ch (valid/ready). A configure word sets one port's watch
// mask and settle time and reports the masked levels at once when the mask is
// nonzero; a sample word carries raw levels and elapsed sample periods, and a
// report leaves on out_ch only once a change has held for the settle time.
// Words for ports beyond the configured count, sample words for unwatched
// ports and configure words with a zero mask are absorbed without a report.
// Throughput is one word per cycle while the skid register is empty: the
// whole state update for a word is a single pass over the addressed port's
// registers. Each report is registered before it reaches out_ch.
// out_ch is fed from an output register backed by a one-word skid register,
// so in_ch keeps taking words while a report waits; in_ch.ready drops only
// when both registers are full and is itself a register output.
// A synchronous reset (rst_n low) clears all per-port state, the event counter
// and the valid flags of both output registers; nothing is watched afterwards.
// Reports on out_ch are never dropped or reordered while out_ch.ready is low.
module multiport_pin_debouncer import mpd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  mpd_in_if.sink        in_ch,
  mpd_out_if.source     out_ch
);

  // Per-port state, one entry per port, addressed by the word's port field.
  logic [PIN_WIDTH-1:0] watch_mask_r  [PORTS];
  logic [PIN_WIDTH-1:0] stable_r      [PORTS];
  logic [PIN_WIDTH-1:0] candidate_r   [PORTS];
  logic [COUNT_W-1:0]   settle_r      [PORTS];
  logic [COUNT_W-1:0]   needed_r      [PORTS];
  logic [31:0]          event_count_r;

  // Output register and the skid register behind it.
  mpd_out_t out_data_r;
  logic     out_valid_r;
  mpd_out_t skid_data_r;
  logic     skid_valid_r;

  logic                  accept;
  logic                  port_ok;
  logic [PORT_IDX_W-1:0] idx;
  logic [PIN_WIDTH-1:0]  lv;
  logic [PIN_WIDTH-1:0]  pm;
  logic [PIN_WIDTH-1:0]  now;
  logic [15:0]           ms_eff;
  logic [DIV_NUM_W-1:0]  div_num;
  logic [DIV_PROD_W-1:0] div_prod;
  logic [DIV_NUM_W-1:0]  div_q;
  logic [COUNT_W-1:0]    need;
  logic [16:0]           settle_sum;
  logic [COUNT_W-1:0]    settle_sat;

  // Next values of the addressed entry.
  logic                  entry_we;
  logic [PIN_WIDTH-1:0]  mask_nxt;
  logic [PIN_WIDTH-1:0]  stable_nxt;
  logic [PIN_WIDTH-1:0]  candidate_nxt;
  logic [COUNT_W-1:0]    settle_nxt;
  logic [COUNT_W-1:0]    needed_nxt;

  logic                  res_valid;
  mpd_out_t              res_data;

  assign in_ch.ready  = !skid_valid_r;
  assign accept       = in_ch.valid && !skid_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign port_ok = ({1'b0, in_ch.data.port} < PORT_LIMIT);
  assign idx     = in_ch.data.port[PORT_IDX_W-1:0];
  assign lv      = in_ch.data.levels[PIN_WIDTH-1:0];
  assign pm      = in_ch.data.pin_mask[PIN_WIDTH-1:0];
  assign now     = lv & watch_mask_r[idx];

  // Settle time in sample periods, rounded up and saturated.
  assign ms_eff   = (in_ch.data.settle_ms == 16'd0) ? 16'(DEFAULT_SETTLE_MS)
                                                    : in_ch.data.settle_ms;
  assign div_num  = DIV_NUM_W'(ms_eff) + DIV_NUM_W'(SAMPLE_PERIOD_MS - 1);
  assign div_prod = DIV_PROD_W'(div_num) * DIV_PROD_W'(DIV_RECIP);
  assign div_q    = DIV_NUM_W'(div_prod >> DIV_SHIFT);
  assign need     = (div_q > DIV_NUM_W'(COUNT_MAX)) ? COUNT_MAX
                                                    : div_q[COUNT_W-1:0];

  // Elapsed periods accumulate with saturation.
  assign settle_sum = 17'(settle_r[idx]) + 17'(in_ch.data.elapsed);
  assign settle_sat = (settle_sum > 17'(COUNT_MAX)) ? COUNT_MAX
                                                    : settle_sum[COUNT_W-1:0];

  always_comb begin
    entry_we      = 1'b0;
    mask_nxt      = watch_mask_r[idx];
    stable_nxt    = stable_r[idx];
    candidate_nxt = candidate_r[idx];
    settle_nxt    = settle_r[idx];
    needed_nxt    = needed_r[idx];
    res_valid     = 1'b0;
    res_data.event_port   = in_ch.data.port;
    res_data.stable_out   = '0;
    res_data.changed_bits = '0;
    res_data.event_number = event_count_r + 32'd1;

    if (accept && port_ok) begin
      if (in_ch.data.func == FUNC_CONFIGURE) begin
        // Take the masked levels as settled and report them if watched.
        entry_we      = 1'b1;
        mask_nxt      = pm;
        stable_nxt    = lv & pm;
        candidate_nxt = lv & pm;
        settle_nxt    = '0;
        needed_nxt    = need;
        res_valid     = (pm != '0);
        res_data.stable_out = 32'(lv & pm);
      end else if (watch_mask_r[idx] != '0) begin
        if (now != candidate_r[idx]) begin
          // A new candidate restarts settling.
          entry_we      = 1'b1;
          candidate_nxt = now;
          settle_nxt    = '0;
        end else if (now != stable_r[idx]) begin
          entry_we = 1'b1;
          if (settle_sat < needed_r[idx]) begin
            settle_nxt = settle_sat;
          end else begin
            // The candidate has held long enough: it becomes stable.
            stable_nxt = now;
            settle_nxt = '0;
            res_valid  = 1'b1;
            res_data.stable_out   = 32'(now);
            res_data.changed_bits = 32'(now ^ stable_r[idx]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PORTS; i++) begin
        watch_mask_r[i] <= '0;
        stable_r[i]     <= '0;
        candidate_r[i]  <= '0;
        settle_r[i]     <= '0;
        needed_r[i]     <= '0;
      end
      event_count_r <= '0;
    end else begin
      if (entry_we) begin
        watch_mask_r[idx] <= mask_nxt;
        stable_r[idx]     <= stable_nxt;
        candidate_r[idx]  <= candidate_nxt;
        settle_r[idx]     <= settle_nxt;
        needed_r[idx]     <= needed_nxt;
      end
      if (res_valid) begin
        event_count_r <= event_count_r + 32'd1;
      end
    end
  end

  // Output register with skid. While the skid register is full no word is
  // taken, so its contents always move to the output before new reports.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : res_data;
    end else if (res_valid) begin
      skid_data_r <= res_data;
    end
  end

endmodule

// ===== rtl/mpd_checker.sv =====
`timescale 1ns / 1ps
`include "multiport_pin_debouncer_defines.svh"

module mpd_checker import mpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  mpd_in_if.sink    in_ch,
  mpd_out_if.source out_ch
);

  logic        out_fire;
  logic        seen_r;
  logic [31:0] last_number_r;

  assign out_fire = out_ch.valid && out_ch.ready;

  // Remember the event number of the last delivered report.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_fire) begin
      seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      last_number_r <= out_ch.data.event_number;
    end
  end

  // A stalled report stays offered and unchanged.
  `MPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
  `MPD_ASSERT_NEXT(a_out_stable, clk, rst_n, out_ch.valid && !out_ch.ready, $stable(out_ch.data))

  // Reports are delivered in order with none lost or repeated.
  `MPD_ASSERT_SAME(a_number_seq, clk, rst_n, out_fire && seen_r, out_ch.data.event_number == last_number_r + 32'd1)

  // Only ports that exist are reported.
  `MPD_ASSERT_SAME(a_port_range, clk, rst_n, out_ch.valid, {1'b0, out_ch.data.event_port} < PORT_LIMIT)

  // Input back-pressure only ever comes from a report waiting at the output.
  `MPD_ASSERT_SAME(a_ready_cause, clk, rst_n, !in_ch.ready, out_ch.valid)

endmodule

bind multiport_pin_debouncer mpd_checker u_mpd_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
